// ----- src/brs_pkg.sv -----
// Shared types and constants for the branch reservation station.
`default_nettype none
package brs_pkg;

  typedef enum logic [1:0] {
    OP_ISSUE     = 2'd0,
    OP_DISPATCH  = 2'd1,
    OP_BROADCAST = 2'd2,
    OP_FLUSH     = 2'd3
  } op_e;

  typedef struct packed {
    logic [7:0]  kind;
    logic [31:0] op1;
    logic        op1_ready;
    logic [31:0] op2;
    logic        op2_ready;
    logic [31:0] next_pc;
    logic [31:0] target;
    logic [30:0] dest;
  } entry_t;

  // Control shared by every cell in one cycle.
  typedef struct packed {
    logic        flush;
    logic        broadcast;
    logic [30:0] bc_tag;
    logic [31:0] bc_value;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- src/brs_cell.sv -----
// One slot of the station: holds an entry, snoops broadcasts, shifts toward the head.
`default_nettype none
module brs_cell (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  brs_pkg::cell_ctrl_t  ctrl_i,
  input  wire                  load_i,
  input  brs_pkg::entry_t      load_data_i,
  input  wire                  shift_i,
  input  brs_pkg::entry_t      next_data_i,
  input  wire                  next_valid_i,
  input  wire                  pop_i,
  output logic                 valid_o,
  output logic                 ready_o,
  output brs_pkg::entry_t      data_o
);

  logic            valid_q, valid_d;
  brs_pkg::entry_t data_q, data_d;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (ctrl_i.flush) begin
      valid_d = 1'b0;
    end else if (load_i) begin
      valid_d = 1'b1;
      data_d  = load_data_i;
    end else if (shift_i) begin
      valid_d = next_valid_i;
      data_d  = next_data_i;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end else if (ctrl_i.broadcast && valid_q) begin
      if (!data_q.op1_ready && data_q.op1 == {1'b0, ctrl_i.bc_tag}) begin
        data_d.op1       = ctrl_i.bc_value;
        data_d.op1_ready = 1'b1;
      end
      if (!data_q.op2_ready && data_q.op2 == {1'b0, ctrl_i.bc_tag}) begin
        data_d.op2       = ctrl_i.bc_value;
        data_d.op2_ready = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign ready_o = valid_q && data_q.op1_ready && data_q.op2_ready;
  assign data_o  = data_q;

endmodule
`default_nettype wire

// ----- src/branch_reservation_station.sv -----
// Top level of the branch reservation station: a chain of entry cells in age order.
// The result of an accepted command is held in the output register in the next cycle.
// Throughput: one command per cycle while the result side keeps up.
// The command is applied to the whole cell chain at once.
// Reset clears every valid bit and the result valid flag; entry and result payloads
// are not reset.
`default_nettype none
module branch_reservation_station #(
  parameter int unsigned ENTRIES = 8
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [1:0]  opcode_i,
  input  wire  [7:0]  branch_kind_i,
  input  wire  [31:0] src1_value_i,
  input  wire         src1_ready_i,
  input  wire  [31:0] src2_value_i,
  input  wire         src2_ready_i,
  input  wire  [31:0] next_pc_i,
  input  wire  [31:0] target_i,
  input  wire  [30:0] tag_i,
  input  wire  [31:0] result_value_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic        accepted_o,
  output logic [5:0]  free_slots_o,
  output logic        out_valid_flag_o,
  output logic [7:0]  out_branch_kind_o,
  output logic [31:0] out_src1_o,
  output logic [31:0] out_src2_o,
  output logic [31:0] out_next_pc_o,
  output logic [31:0] out_target_o,
  output logic [30:0] out_dest_o
);

  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  // A command is taken whenever the output register is empty or drains this cycle.
  logic in_xfer;
  logic res_valid_q;
  assign in_stall_o = res_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  brs_pkg::op_e op;
  assign op = brs_pkg::op_e'(opcode_i);

  brs_pkg::cell_ctrl_t ctrl;
  assign ctrl.flush     = in_xfer && op == brs_pkg::OP_FLUSH;
  assign ctrl.broadcast = in_xfer && op == brs_pkg::OP_BROADCAST;
  assign ctrl.bc_tag    = tag_i;
  assign ctrl.bc_value  = result_value_i;

  brs_pkg::entry_t new_entry;
  assign new_entry.kind      = branch_kind_i;
  assign new_entry.op1       = src1_value_i;
  assign new_entry.op1_ready = src1_ready_i;
  assign new_entry.op2       = src2_value_i;
  assign new_entry.op2_ready = src2_ready_i;
  assign new_entry.next_pc   = next_pc_i;
  assign new_entry.target    = target_i;
  assign new_entry.dest      = tag_i;

  logic [ENTRIES-1:0]    cell_valid, cell_ready, load, shift, pop;
  brs_pkg::entry_t       cell_data [ENTRIES];
  logic [ENTRIES-1:0]    first_ready, before_ready;
  logic                  any_ready;
  logic [CntW-1:0]       count;
  brs_pkg::entry_t       sel_data;

  // Valid cells always form a prefix, so the first empty cell takes an issue.
  // The oldest ready cell is found with a prefix mask; it and every younger cell
  // take their younger neighbor's contents, which closes the gap.
  always_comb begin
    before_ready[0] = 1'b0;
    for (int i = 1; i < ENTRIES; i++) begin
      before_ready[i] = before_ready[i-1] | cell_ready[i-1];
    end
    first_ready = cell_ready & ~before_ready;
    any_ready   = |cell_ready;
    sel_data    = '0;
    count       = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (first_ready[i]) sel_data = sel_data | cell_data[i];
      count = count + CntW'(cell_valid[i]);
    end
    for (int i = 0; i < ENTRIES; i++) begin
      load[i] = in_xfer && op == brs_pkg::OP_ISSUE && !cell_valid[i] &&
                (i == 0 || cell_valid[i == 0 ? 0 : i-1]);
      shift[i] = in_xfer && op == brs_pkg::OP_DISPATCH &&
                 (first_ready[i] || before_ready[i]) && (i < ENTRIES - 1);
      pop[i]   = in_xfer && op == brs_pkg::OP_DISPATCH &&
                 (first_ready[i] || before_ready[i]) && (i == ENTRIES - 1);
    end
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    brs_pkg::entry_t nd;
    logic            nv;
    if (g < ENTRIES - 1) begin : g_mid
      assign nd = cell_data[g+1];
      assign nv = cell_valid[g+1];
    end else begin : g_end
      assign nd = '0;
      assign nv = 1'b0;
    end
    brs_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .load_i      (load[g]),
      .load_data_i (new_entry),
      .shift_i     (shift[g]),
      .next_data_i (nd),
      .next_valid_i(nv),
      .pop_i       (pop[g]),
      .valid_o     (cell_valid[g]),
      .ready_o     (cell_ready[g]),
      .data_o      (cell_data[g])
    );
  end

  // Result register: computed from the state before the edge and the command.
  logic            acc_d, dv_d;
  logic [CntW-1:0] cnt_after;
  always_comb begin
    acc_d     = 1'b0;
    dv_d      = 1'b0;
    cnt_after = count;
    case (op)
      brs_pkg::OP_ISSUE: begin
        acc_d = count != CntW'(ENTRIES);
        if (acc_d) cnt_after = count + CntW'(1);
      end
      brs_pkg::OP_DISPATCH: begin
        dv_d = any_ready;
        if (dv_d) cnt_after = count - CntW'(1);
      end
      brs_pkg::OP_FLUSH: cnt_after = '0;
      default: cnt_after = count;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      res_valid_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      accepted_o        <= acc_d;
      free_slots_o      <= 6'(ENTRIES) - 6'(cnt_after);
      out_valid_flag_o  <= dv_d;
      out_branch_kind_o <= dv_d ? sel_data.kind    : '0;
      out_src1_o        <= dv_d ? sel_data.op1     : '0;
      out_src2_o        <= dv_d ? sel_data.op2     : '0;
      out_next_pc_o     <= dv_d ? sel_data.next_pc : '0;
      out_target_o      <= dv_d ? sel_data.target  : '0;
      out_dest_o        <= dv_d ? sel_data.dest    : '0;
    end
  end

  assign out_valid_o = res_valid_q;

`ifndef SYNTHESIS
  a_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_valid & (cell_valid + ENTRIES'(1))) == '0)
    else $error("valid cells do not form a prefix");
  a_one_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(first_ready))
    else $error("more than one oldest ready cell");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && op == brs_pkg::OP_FLUSH |=> cell_valid == '0)
    else $error("flush left valid cells");
`endif

endmodule
`default_nettype wire
